>>> rtl/tob_pkg.sv
// Shared types, constants and operation codes for the top-of-book symbol table.
`timescale 1ns / 1ps

package tob_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LIM_W = 17;

	localparam logic [10:0] ACTIVE_RESET = 11'd1024;

	localparam logic [2:0] OP_QUOTE = 3'd0;
	localparam logic [2:0] OP_TRADE = 3'd1;
	localparam logic [2:0] OP_BID   = 3'd2;
	localparam logic [2:0] OP_ASK   = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] symbol;
		logic [31:0] bid_tick;
		logic [31:0] bid_size;
		logic [31:0] ask_tick;
		logic [31:0] ask_size;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [63:0] event_time;
	} item_t;

	typedef struct packed {
		logic        status;
		logic [31:0] top_bid;
		logic [31:0] top_bid_size;
		logic [31:0] top_ask;
		logic [31:0] top_ask_size;
		logic [31:0] trade_price;
		logic [31:0] trade_size;
		logic [63:0] update_time;
		logic [31:0] update_total;
		logic [31:0] open_price;
		logic [47:0] all_updates;
	} result_t;

	typedef struct packed {
		logic [31:0] bid_px;
		logic [31:0] bid_qty;
		logic [31:0] ask_px;
		logic [31:0] ask_qty;
		logic [31:0] trd_px;
		logic [31:0] trd_qty;
		logic [63:0] stamp;
		logic [31:0] count;
		logic [31:0] open_px;
	} entry_t;

endpackage

>>> rtl/tob_item_if.sv
// Input channel carrying one market-data item per beat.
`timescale 1ns / 1ps

interface tob_item_if import tob_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/tob_result_if.sv
// Output channel carrying one table entry result per beat.
`timescale 1ns / 1ps

interface tob_result_if import tob_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/top_of_book_symbol_table_top.sv
// Top level of the top-of-book symbol table with its entry memory and update logic.
`timescale 1ns / 1ps

// The block accepts one item per cycle while ready is high and returns one registered
// result beat per item, the table entry after the operation. The entry memory has one read
// and one write port; the read-modify-write is done in the update stage, and an item that
// hits the entry written by the item just ahead of it takes its data from a forwarding
// register. After reset the block clears the memory, one entry per cycle, all TABLE_DEPTH
// (1024) entries, with item ready low; configuration writes are taken meanwhile. The
// output register lets the next item in while a result beat waits to be taken.
module top_of_book_symbol_table_top import tob_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	tob_item_if.sink    item,
	tob_result_if.source result
);

	entry_t mem [TABLE_DEPTH];

	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic [10:0]      active_q;
	logic [47:0]      grand_total_q;

	logic             valid_s1;
	item_t            item_s1;
	entry_t           rd_s1;
	entry_t           fwd_s1;
	logic             hit_s1;

	logic             out_valid_q;
	result_t          out_q;

	logic             accept;
	logic             advance;
	logic [LIM_W-1:0] limit;
	logic             in_range;
	logic             is_update;
	logic             wr_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] idx_in;
	entry_t           old_entry;
	entry_t           new_entry;
	logic             count_grows;
	logic [47:0]      total_next;
	logic [32:0]      mid_sum;
	result_t          res_next;

	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !clr_busy_q && (!valid_s1 || advance);
	assign accept = item.valid && item.ready;

	assign idx_in = item.payload.symbol[IDX_W-1:0];
	assign idx_s1 = item_s1.symbol[IDX_W-1:0];

	always_comb begin
		if (LIM_W'(active_q) > LIM_W'(TABLE_DEPTH)) begin
			limit = LIM_W'(TABLE_DEPTH);
		end else begin
			limit = LIM_W'(active_q);
		end
	end

	assign in_range = LIM_W'(item_s1.symbol) < limit;
	assign is_update = (item_s1.operation == OP_QUOTE) || (item_s1.operation == OP_TRADE) ||
		(item_s1.operation == OP_BID) || (item_s1.operation == OP_ASK);
	assign wr_s1 = valid_s1 && in_range && is_update;

	assign old_entry = hit_s1 ? fwd_s1 : rd_s1;
	assign mid_sum = {1'b0, item_s1.bid_tick} + {1'b0, item_s1.ask_tick};
	assign count_grows = is_update && in_range && (old_entry.count != '1);

	always_comb begin
		new_entry = old_entry;
		case (item_s1.operation)
			OP_QUOTE: begin
				new_entry.bid_px  = item_s1.bid_tick;
				new_entry.bid_qty = item_s1.bid_size;
				new_entry.ask_px  = item_s1.ask_tick;
				new_entry.ask_qty = item_s1.ask_size;
				if (old_entry.open_px == '0) begin
					new_entry.open_px = mid_sum[32:1];
				end
			end
			OP_TRADE: begin
				new_entry.trd_px  = item_s1.price;
				new_entry.trd_qty = item_s1.quantity;
				if (old_entry.open_px == '0) begin
					new_entry.open_px = item_s1.price;
				end
			end
			OP_BID: begin
				new_entry.bid_px  = item_s1.price;
				new_entry.bid_qty = item_s1.quantity;
			end
			OP_ASK: begin
				new_entry.ask_px  = item_s1.price;
				new_entry.ask_qty = item_s1.quantity;
			end
			default: begin
			end
		endcase
		if (is_update) begin
			new_entry.stamp = item_s1.event_time;
		end
		if (count_grows) begin
			new_entry.count = old_entry.count + 32'd1;
		end
	end

	always_comb begin
		total_next = grand_total_q;
		if (count_grows && (grand_total_q != '1)) begin
			total_next = grand_total_q + 48'd1;
		end
	end

	always_comb begin
		res_next = '0;
		res_next.all_updates = total_next;
		if (!in_range) begin
			res_next.status = STATUS_RANGE;
		end else begin
			res_next.status        = STATUS_OK;
			res_next.top_bid       = new_entry.bid_px;
			res_next.top_bid_size  = new_entry.bid_qty;
			res_next.top_ask       = new_entry.ask_px;
			res_next.top_ask_size  = new_entry.ask_qty;
			res_next.trade_price   = new_entry.trd_px;
			res_next.trade_size    = new_entry.trd_qty;
			res_next.update_time   = new_entry.stamp;
			res_next.update_total  = new_entry.count;
			res_next.open_price    = new_entry.open_px;
		end
	end

	// Entry memory: the clearing pass owns the write port until it finishes.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (advance && wr_s1) begin
			mem[idx_s1] <= new_entry;
		end
		if (accept) begin
			rd_s1 <= mem[idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item.payload;
			fwd_s1  <= new_entry;
		end
		if (advance) begin
			out_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q    <= 1'b1;
			clr_cnt_q     <= '0;
			active_q      <= ACTIVE_RESET;
			grand_total_q <= '0;
			valid_s1      <= 1'b0;
			hit_s1        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
				if (clr_cnt_q == IDX_W'(TABLE_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (advance) begin
				grand_total_q <= total_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				hit_s1   <= advance && wr_s1 && (idx_s1 == idx_in);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

endmodule

>>> rtl/tob_checker.sv
// Port-level checker for the top-of-book symbol table and its bind statement.
`timescale 1ns / 1ps

module tob_checker import tob_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res
);

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("Result beat changed while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STATUS_RANGE) |->
		(res.top_bid == '0) && (res.top_ask == '0) && (res.update_total == '0) &&
		(res.update_time == '0) && (res.open_price == '0))
		else $error("Rejected symbol returned nonzero entry fields.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STATUS_OK) && (res.update_total == '0) |->
		(res.open_price == '0) && (res.update_time == '0) && (res.trade_size == '0))
		else $error("Entry with no updates holds data.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STATUS_OK) && (res.update_total != '0) |->
		(res.all_updates != '0))
		else $error("Entry count is nonzero while the running total is zero.");

endmodule

bind top_of_book_symbol_table_top tob_checker u_tob_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res       (result.payload)
);
